// ----- src/vmt_pkg.sv -----
// Shared types and constants for the 4x4 vector-by-matrix transform.
// No dependencies; every other file imports this package.
`default_nettype none

package vmt_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumCoef  = NumLanes * NumLanes;
  localparam int unsigned CoefIdxW = $clog2(NumCoef);
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned PairW    = ProdW + 1;
  localparam int unsigned SumW     = ProdW + 2;

  typedef enum logic [0:0] {
    OP_WRITE     = 1'b0,
    OP_TRANSFORM = 1'b1
  } opcode_e;

  typedef logic [DataW-1:0]                data_t;
  typedef logic [NumLanes-1:0][DataW-1:0]  vec_t;
  typedef logic [NumCoef-1:0][DataW-1:0]   matrix_t;

  // Identity coefficient in Q format.
  localparam data_t CoefOne = DataW'(64'd1 << FracBits);

  // Clock enables for the two lane pipeline stages.
  typedef struct packed {
    logic en_mul;
    logic en_add;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- src/vmt_if.sv -----
// Valid/ready channel interfaces for the transform block.
// Depends on vmt_pkg for field widths.
`default_nettype none

interface vmt_in_if import vmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [CoefIdxW-1:0] coef_index;
  logic [DataW-1:0]    coef_value;
  logic [DataW-1:0]    in_a;
  logic [DataW-1:0]    in_b;
  logic [DataW-1:0]    in_c;
  logic [DataW-1:0]    in_d;

  modport source (output valid, opcode, coef_index, coef_value, in_a, in_b, in_c, in_d,
                  input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, in_a, in_b, in_c, in_d,
                  output ready);
endinterface

interface vmt_out_if import vmt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] out_a;
  logic [DataW-1:0] out_b;
  logic [DataW-1:0] out_c;
  logic [DataW-1:0] out_d;
  logic             saturated;

  modport source (output valid, out_a, out_b, out_c, out_d, saturated, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, saturated, output ready);
endinterface

`default_nettype wire

// ----- src/vmt_coef_store.sv -----
// Coefficient register file, 16 entries, identity after reset.
// Depends on vmt_pkg.
`default_nettype none

module vmt_coef_store import vmt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [CoefIdxW-1:0] idx_i,
  input  wire data_t               value_i,
  output matrix_t                  coef_o
);

  matrix_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Load one on the diagonal, zero elsewhere.
      for (int k = 0; k < NumLanes; k++) begin
        for (int j = 0; j < NumLanes; j++) begin
          coef_q[NumLanes * k + j] <= (j == k) ? CoefOne : '0;
        end
      end
    end else if (we_i) begin
      coef_q[idx_i] <= value_i;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ----- src/vmt_lane.sv -----
// One output column: four multipliers, a registered pair-sum stage, then the
// final add, floor shift and saturation. Depends on vmt_pkg.
`default_nettype none

module vmt_lane import vmt_pkg::*; (
  input  wire logic       clk_i,
  input  wire lane_ctrl_t ctrl_i,
  input  wire vec_t       vec_i,
  input  wire vec_t       col_i,
  output data_t           res_o,
  output logic            sat_o
);

  localparam logic signed [SumW-1:0] SatMax = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sd2147483648);

  logic signed [ProdW-1:0] prod_d [NumLanes];
  logic signed [ProdW-1:0] prod_q [NumLanes];
  logic signed [PairW-1:0] pair_d [2];
  logic signed [PairW-1:0] pair_q [2];
  logic signed [SumW-1:0]  total;
  logic signed [SumW-1:0]  shifted;

  always_comb begin
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] c;
    for (int k = 0; k < NumLanes; k++) begin
      x = vec_i[k];
      c = col_i[k];
      prod_d[k] = x * c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      for (int k = 0; k < NumLanes; k++) prod_q[k] <= prod_d[k];
    end
  end

  assign pair_d[0] = PairW'(prod_q[0]) + PairW'(prod_q[1]);
  assign pair_d[1] = PairW'(prod_q[2]) + PairW'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_add) begin
      pair_q[0] <= pair_d[0];
      pair_q[1] <= pair_d[1];
    end
  end

  // Arithmetic shift of the exact sum rounds toward minus infinity.
  assign total   = SumW'(pair_q[0]) + SumW'(pair_q[1]);
  assign shifted = total >>> FracBits;

  always_comb begin
    sat_o = 1'b0;
    res_o = shifted[DataW-1:0];
    if (shifted > SatMax) begin
      res_o = SatMax[DataW-1:0];
      sat_o = 1'b1;
    end else if (shifted < SatMin) begin
      res_o = SatMin[DataW-1:0];
      sat_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- src/vector_matrix_4x4_transform.sv -----
// Top level of the 4x4 Q16.16 vector-by-matrix transform: coefficient store,
// four column lanes and the merging output register. Depends on vmt_pkg,
// vmt_if, vmt_coef_store and vmt_lane.
//
//   channel  direction  transfer carries
//   in_i     sink       opcode, coef_index, coef_value, in_a..in_d
//   out_o    source     out_a..out_d, saturated
//
// One item is taken per cycle while in_i.ready is high. A transform result
// is presented once it has passed the registers in order (products register
// at the transfer edge, then pair sum, then final sum and saturate into the
// output register); a coefficient write takes effect for the next item.
// Reset loads the identity matrix and empties the pipeline.
// Each stage holds while the one after it is full and stalled, so bubbles
// fill in and the input stalls only once all three stages are full.
`default_nettype none

module vector_matrix_4x4_transform import vmt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vmt_in_if.sink     in_i,
  vmt_out_if.source  out_o
);

  logic       mul_v_q, add_v_q, out_v_q;
  logic       en_mul, en_add, en_out;
  logic       in_xfer, is_write, is_xform;
  lane_ctrl_t lane_ctrl;
  matrix_t    coef;
  vec_t       vec;
  vec_t       col [NumLanes];
  data_t      lane_res [NumLanes];
  logic [NumLanes-1:0] lane_sat;

  data_t res_q [NumLanes];
  logic  sat_q;

  assign en_out = !out_v_q || out_o.ready;
  assign en_add = !add_v_q || en_out;
  assign en_mul = !mul_v_q || en_add;

  assign in_i.ready = en_mul;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign is_write   = in_xfer && (in_i.opcode == OP_WRITE);
  assign is_xform   = in_xfer && (in_i.opcode == OP_TRANSFORM);

  assign lane_ctrl.en_mul = en_mul;
  assign lane_ctrl.en_add = en_add;

  vmt_coef_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (is_write),
    .idx_i   (in_i.coef_index),
    .value_i (in_i.coef_value),
    .coef_o  (coef)
  );

  assign vec[0] = in_i.in_a;
  assign vec[1] = in_i.in_b;
  assign vec[2] = in_i.in_c;
  assign vec[3] = in_i.in_d;

  for (genvar j = 0; j < NumLanes; j++) begin : g_lane
    for (genvar k = 0; k < NumLanes; k++) begin : g_col
      assign col[j][k] = coef[NumLanes * k + j];
    end

    vmt_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .vec_i  (vec),
      .col_i  (col[j]),
      .res_o  (lane_res[j]),
      .sat_o  (lane_sat[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      add_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_mul) mul_v_q <= is_xform;
      if (en_add) add_v_q <= mul_v_q;
      if (en_out) out_v_q <= add_v_q;
    end
  end

  // Merge the lanes: collect the four elements and OR the clip flags.
  always_ff @(posedge clk_i) begin
    if (en_out && add_v_q) begin
      for (int j = 0; j < NumLanes; j++) res_q[j] <= lane_res[j];
      sat_q <= |lane_sat;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.out_a     = res_q[0];
  assign out_o.out_b     = res_q[1];
  assign out_o.out_c     = res_q[2];
  assign out_o.out_d     = res_q[3];
  assign out_o.saturated = sat_q;

  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == !(mul_v_q && add_v_q && out_v_q && !out_o.ready))
    else $error("input ready does not match pipeline occupancy");

  a_out_from_add : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(add_v_q))
    else $error("result appeared without a pair-sum stage item");

  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && sat_q) |->
      (res_q[0] == 32'h7FFFFFFF || res_q[0] == 32'h80000000 ||
       res_q[1] == 32'h7FFFFFFF || res_q[1] == 32'h80000000 ||
       res_q[2] == 32'h7FFFFFFF || res_q[2] == 32'h80000000 ||
       res_q[3] == 32'h7FFFFFFF || res_q[3] == 32'h80000000))
    else $error("saturated flag set without a clipped element");

endmodule

`default_nettype wire
